FILE: rtl/ring_neighbor_resource_arbiter_macros.svh
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: assertion macros
// Concurrent check wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH
`define RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define RNRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define RNRA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RNRA_ASSERT(lbl, clk, rst, prop, msg)
`define RNRA_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/rnra_pkg.sv
// ----------------------------------------------------------------------------
// rnra_pkg
// Shared types and constants of the ring neighbor resource arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rnra_pkg;

   // field widths fixed by the interface
   localparam int SEAT_W = 4;
   localparam int CSR_W  = 5;

   // seat count register
   localparam logic [CSR_W-1:0] ACTIVE_SEATS_RESET = 5'd5;
   localparam int               MIN_SEATS          = 2;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // item opcodes
   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // one result item
   typedef struct packed {
      logic [SEAT_W-1:0] target_seat;
      logic              granted;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: rtl/rnra_front.sv
// ----------------------------------------------------------------------------
// rnra_front
// Holds the seat count register, takes input items, drops seats outside the
// ring and resolves the neighbor indices that the back end needs.
// ----------------------------------------------------------------------------
`default_nettype none

module rnra_front #(
   parameter int MAX_SEATS = 16,
   parameter int CMD_W     = 2 + 5 * $clog2(MAX_SEATS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [rnra_pkg::CSR_W-1:0] csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_type,
   input  wire logic [rnra_pkg::SEAT_W-1:0] req_seat,
   input  wire logic                      q_full,
   output logic                           q_push,
   output logic [CMD_W-1:0]               q_push_data
);
   import rnra_pkg::*;

   localparam int IW = $clog2(MAX_SEATS);
   localparam int NW = $clog2(MAX_SEATS + 1);
   localparam int CW = (NW > CSR_W) ? NW : CSR_W;

   logic [CSR_W-1:0] active_seats_ff;
   logic [CSR_W-1:0] active_seats_in;

   logic [CW-1:0] raw_n;
   logic [CW-1:0] ring_n;
   logic [CW-1:0] seat_cw;
   logic [CW-1:0] left_cw;
   logic [CW-1:0] right_cw;
   logic [CW-1:0] left2_cw;
   logic [CW-1:0] right2_cw;
   logic          in_ring;
   logic          two_seats;

   function automatic logic [CW-1:0] left_of(input logic [CW-1:0] a, input logic [CW-1:0] m);
      return (a == '0) ? (m - CW'(1)) : (a - CW'(1));
   endfunction

   function automatic logic [CW-1:0] right_of(input logic [CW-1:0] a, input logic [CW-1:0] m);
      return ((a + CW'(1)) == m) ? '0 : (a + CW'(1));
   endfunction

   // seat count register, raw value kept as written
   always_comb begin
      active_seats_in = csr_wr_en ? csr_wr_data : active_seats_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_seats_ff <= ACTIVE_SEATS_RESET;
      end else begin
         active_seats_ff <= active_seats_in;
      end
   end

   // effective ring size, clamped to the supported range
   always_comb begin
      raw_n = CW'(active_seats_ff);
      priority if (raw_n < CW'(MIN_SEATS)) begin
         ring_n = CW'(MIN_SEATS);
      end else if (raw_n > CW'(MAX_SEATS)) begin
         ring_n = CW'(MAX_SEATS);
      end else begin
         ring_n = raw_n;
      end
   end

   // neighbor indices: both neighbors, and the outer neighbor of each
   always_comb begin
      seat_cw   = CW'(req_seat);
      in_ring   = (seat_cw < ring_n);
      two_seats = (ring_n == CW'(MIN_SEATS));
      left_cw   = left_of(seat_cw, ring_n);
      right_cw  = right_of(seat_cw, ring_n);
      left2_cw  = left_of(left_cw, ring_n);
      right2_cw = right_of(right_cw, ring_n);
   end

   // out-of-ring items are taken and dropped
   assign req_stall   = q_full;
   assign q_push      = req_valid && !q_full && in_ring;
   assign q_push_data = {req_type, two_seats, seat_cw[IW-1:0], left_cw[IW-1:0],
                         right_cw[IW-1:0], left2_cw[IW-1:0], right2_cw[IW-1:0]};

endmodule

`default_nettype wire

FILE: rtl/rnra_queue.sv
// ----------------------------------------------------------------------------
// rnra_queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rnra_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [WIDTH-1:0]      head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CNTW-1:0]  count_ff;
   logic [CNTW-1:0]  count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rnra_back.sv
// ----------------------------------------------------------------------------
// rnra_back
// Carries out queued requests and releases against the seat state and
// drives the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rnra_back #(
   parameter int MAX_SEATS = 16,
   parameter int CMD_W     = 2 + 5 * $clog2(MAX_SEATS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire logic [CMD_W-1:0]       q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rnra_pkg::rsp_item_type      rsp_item
);
   import rnra_pkg::*;

   localparam int IW = $clog2(MAX_SEATS);

   // sequencer phases
   localparam logic PH_RUN    = 1'b0;
   localparam logic PH_SECOND = 1'b1;

   logic                 phase_ff;
   logic                 phase_in;
   logic [MAX_SEATS-1:0] eat_ff;
   logic [MAX_SEATS-1:0] eat_in;
   logic [MAX_SEATS-1:0] hun_ff;
   logic [MAX_SEATS-1:0] hun_in;
   logic [SEAT_W-1:0]    pend_seat_ff;
   logic [SEAT_W-1:0]    pend_seat_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_item_type         rsp_ff;
   rsp_item_type         rsp_in;

   logic          c_rel;
   logic          c_two;
   logic [IW-1:0] c_seat;
   logic [IW-1:0] c_left;
   logic [IW-1:0] c_right;
   logic [IW-1:0] c_left2;
   logic [IW-1:0] c_right2;

   logic [MAX_SEATS-1:0] oh_seat;
   logic [MAX_SEATS-1:0] oh_left;
   logic [MAX_SEATS-1:0] oh_right;
   logic [MAX_SEATS-1:0] eat_rel;
   logic [MAX_SEATS-1:0] hun_rel;
   logic [MAX_SEATS-1:0] eat_lg;
   logic [MAX_SEATS-1:0] hun_lg;
   logic                 grant_req;
   logic                 grant_left;
   logic                 grant_right;
   logic                 out_free;

   assign {c_rel, c_two, c_seat, c_left, c_right, c_left2, c_right2} = q_data;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // grant checks; a release frees the seat before its neighbors are tried
   always_comb begin
      oh_seat  = MAX_SEATS'(1) << c_seat;
      oh_left  = MAX_SEATS'(1) << c_left;
      oh_right = MAX_SEATS'(1) << c_right;

      grant_req = !eat_ff[c_left] && !eat_ff[c_right];

      eat_rel    = eat_ff & ~oh_seat;
      hun_rel    = hun_ff & ~oh_seat;
      grant_left = hun_rel[c_left] && !eat_rel[c_left2];
      eat_lg     = grant_left ? (eat_rel | oh_left) : eat_rel;
      hun_lg     = grant_left ? (hun_rel & ~oh_left) : hun_rel;
      // with two seats the single neighbor is tried only once
      grant_right = !c_two && hun_lg[c_right] && !eat_lg[c_right2];
   end

   // sequencer: one queued item per cycle while the output is free; a second grant holds the queue until it is sent
   always_comb begin
      phase_in     = phase_ff;
      eat_in       = eat_ff;
      hun_in       = hun_ff;
      pend_seat_in = pend_seat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      priority if (phase_ff == PH_SECOND) begin
         if (out_free) begin
            rsp_in.target_seat = pend_seat_ff;
            rsp_in.granted     = 1'b1;
            rsp_in.last        = 1'b1;
            rsp_valid_in       = 1'b1;
            phase_in           = PH_RUN;
         end
      end else if (q_valid && out_free) begin
         q_pop = 1'b1;
         if (c_rel == REQ_ACQUIRE) begin
            eat_in             = grant_req ? (eat_ff | oh_seat) : (eat_ff & ~oh_seat);
            hun_in             = grant_req ? (hun_ff & ~oh_seat) : (hun_ff | oh_seat);
            rsp_in.target_seat = SEAT_W'(c_seat);
            rsp_in.granted     = grant_req;
            rsp_in.last        = 1'b1;
            rsp_valid_in       = 1'b1;
         end else begin
            eat_in = grant_right ? (eat_lg | oh_right) : eat_lg;
            hun_in = grant_right ? (hun_lg & ~oh_right) : hun_lg;
            priority if (grant_left) begin
               rsp_in.target_seat = SEAT_W'(c_left);
               rsp_in.granted     = 1'b1;
               rsp_in.last        = !grant_right;
               rsp_valid_in       = 1'b1;
               if (grant_right) begin
                  phase_in     = PH_SECOND;
                  pend_seat_in = SEAT_W'(c_right);
               end
            end else if (grant_right) begin
               rsp_in.target_seat = SEAT_W'(c_right);
               rsp_in.granted     = 1'b1;
               rsp_in.last        = 1'b1;
               rsp_valid_in       = 1'b1;
            end else begin
               rsp_valid_in = 1'b0;
            end
         end
      end else begin
         phase_in = phase_ff;
      end
   end

   // control and seat state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RUN;
         eat_ff       <= '0;
         hun_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         eat_ff       <= eat_in;
         hun_ff       <= hun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      pend_seat_ff <= pend_seat_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ring_neighbor_resource_arbiter.sv
// ----------------------------------------------------------------------------
// ring_neighbor_resource_arbiter
// Grants shared resources to seats in a ring when no neighbor is eating.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (req_type, req_seat) arrive on req_valid/req_stall. A request
//   (REQ_ACQUIRE) grants the seat or marks it hungry and returns one result
//   item, granted or left waiting. A release frees the seat, then tries its
//   left and then its right neighbor, returning one item per grant (none if
//   nothing is granted). rsp_last flags the final item of each input. Seats
//   at or above the ring size are accepted and dropped with no result.
//   csr_wr_en/csr_wr_data write the seat count; write it only while idle.
// Timing:
//   Items pass through the queue to the registered output. The back end
//   takes one queued item per cycle while the output is free; a release
//   that grants both neighbors holds it until the second result is sent,
//   since both results share the single output register. A two-entry queue
//   lets the front keep taking items while the back end or receiver stalls.
// Reset:
//   All seats thinking, seat count 5, queue and output empty. A stalled
//   result holds in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ring_neighbor_resource_arbiter_macros.svh"

module ring_neighbor_resource_arbiter #(
   parameter int MAX_SEATS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [rnra_pkg::CSR_W-1:0]  csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic [rnra_pkg::SEAT_W-1:0] req_seat,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [rnra_pkg::SEAT_W-1:0]      rsp_target_seat,
   output logic                             rsp_granted,
   output logic                             rsp_last
);
   import rnra_pkg::*;

   localparam int IW    = $clog2(MAX_SEATS);
   localparam int CMD_W = 2 + 5 * IW;

   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   logic [CMD_W-1:0] q_head;
   rsp_item_type     rsp_item;

   // front: seat count register and item classification
   rnra_front #(
      .MAX_SEATS (MAX_SEATS),
      .CMD_W     (CMD_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_seat    (req_seat),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // decoupling queue
   rnra_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_data (q_head)
   );

   // back: seat state and result generation
   rnra_back #(
      .MAX_SEATS (MAX_SEATS),
      .CMD_W     (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_target_seat = rsp_item.target_seat;
   assign rsp_granted     = rsp_item.granted;
   assign rsp_last        = rsp_item.last;

   // checks
   `RNRA_ASSERT_NEVER(a_no_push_when_full, clock, reset, q_push && q_full,
      "queue push while full")
   `RNRA_ASSERT(a_wait_is_single, clock, reset, rsp_valid && !rsp_granted |-> rsp_last,
      "waiting result not marked last")
   `RNRA_ASSERT(a_second_follows, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid,
      "second grant result did not follow the first")

endmodule

`default_nettype wire
